### hw/rtl/sfc_pkg.sv
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int unsigned FRAME_BYTES = 10;
  localparam int unsigned POS_W = $clog2(FRAME_BYTES);

  localparam logic [7:0]  FRAME_START   = 8'h7E;
  localparam logic [7:0]  FRAME_VERSION = 8'hFF;
  localparam logic [7:0]  FRAME_LENGTH  = 8'h06;
  localparam logic [7:0]  FRAME_END     = 8'hEF;
  localparam logic [15:0] CK_BASE       = 16'h0105;

  localparam logic OP_RX = 1'b0;
  localparam logic OP_TX = 1'b1;

  // frame byte positions
  localparam logic [POS_W-1:0] POS_START   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_VERSION = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CMD     = POS_W'(3);
  localparam logic [POS_W-1:0] POS_REPLY   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_PARAM_H = POS_W'(5);
  localparam logic [POS_W-1:0] POS_PARAM_L = POS_W'(6);
  localparam logic [POS_W-1:0] POS_CK_H    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CK_L    = POS_W'(8);
  localparam logic [POS_W-1:0] POS_END     = POS_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic        op;
    logic [7:0]  rx_byte;
    logic [7:0]  command;
    logic [15:0] param;
    logic        wants_reply;
  } in_t;

  typedef struct packed {
    logic        is_tx;
    logic [7:0]  tx_byte;
    logic        last;
    logic        completed;
    logic [7:0]  reply_command;
    logic [15:0] reply_param;
  } out_t;

  typedef struct packed {
    logic        is_tx;
    logic [7:0]  command;
    logic        reply;
    logic [15:0] param;
    logic [15:0] cksum;
    logic [7:0]  held_cmd;
    logic [15:0] held_param;
  } job_t;

endpackage

### hw/rtl/sfc_front.sv
`timescale 1ns / 1ps

module sfc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  sfc_pkg::in_t  item,
  output sfc_pkg::job_t job
);
  import sfc_pkg::*;

  localparam int unsigned OLD = FRAME_BYTES - 1;

  logic [7:0]  win_r   [FRAME_BYTES];
  logic [7:0]  win_nxt [FRAME_BYTES];
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic [15:0] held_param_r, held_param_nxt;
  logic [15:0] tx_sum, rx_sum, rx_got;
  logic [7:0]  f_cmd, f_rep, f_ph, f_pl;

  function automatic logic [15:0] frame_sum(input logic [7:0] c, input logic [7:0] r,
                                            input logic [7:0] h, input logic [7:0] l);
    logic [15:0] s;
    s = CK_BASE + {8'h00, c} + {8'h00, r} + {8'h00, h} + {8'h00, l};
    return 16'h0000 - s;
  endfunction

  // window kept as a shift line: tap 0 newest, last tap oldest
  always_comb begin
    win_nxt[0] = item.rx_byte;
    for (int i = 1; i < FRAME_BYTES; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    f_cmd  = win_nxt[OLD - int'(POS_CMD)];
    f_rep  = win_nxt[OLD - int'(POS_REPLY)];
    f_ph   = win_nxt[OLD - int'(POS_PARAM_H)];
    f_pl   = win_nxt[OLD - int'(POS_PARAM_L)];
    rx_got = {win_nxt[OLD - int'(POS_CK_H)], win_nxt[OLD - int'(POS_CK_L)]};
    rx_sum = frame_sum(f_cmd, f_rep, f_ph, f_pl);
    tx_sum = frame_sum(item.command, {7'h00, item.wants_reply},
                       item.param[15:8], item.param[7:0]);

    held_cmd_nxt   = held_cmd_r;
    held_param_nxt = held_param_r;
    if (item.op == OP_TX) begin
      held_cmd_nxt = 8'h00;
    end else if (item.rx_byte == FRAME_END) begin
      held_cmd_nxt = 8'h00;
      if (win_nxt[OLD] == FRAME_START) begin
        win_nxt[OLD] = 8'h00;
        if (rx_sum == rx_got) begin
          held_cmd_nxt   = f_cmd;
          held_param_nxt = {f_ph, f_pl};
        end
      end
    end

    job.is_tx      = item.op;
    job.command    = item.command;
    job.reply      = item.wants_reply;
    job.param      = item.param;
    job.cksum      = tx_sum;
    job.held_cmd   = held_cmd_nxt;
    job.held_param = held_param_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        win_r[i] <= 8'h00;
      end
      held_cmd_r   <= 8'h00;
      held_param_r <= 16'h0000;
    end else if (accept) begin
      if (item.op == OP_RX) begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
      held_cmd_r   <= held_cmd_nxt;
      held_param_r <= held_param_nxt;
    end
  end

endmodule

### hw/rtl/sfc_queue.sv
`timescale 1ns / 1ps

module sfc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  sfc_pkg::job_t wr_job,
  input  logic          rd_en,
  output sfc_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);
  import sfc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == CW'(0));
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

### hw/rtl/sfc_back.sv
`timescale 1ns / 1ps

module sfc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  sfc_pkg::job_t q_job,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output sfc_pkg::out_t out_data
);
  import sfc_pkg::*;

  logic             out_valid_r;
  out_t             out_r;
  out_t             res;
  logic [POS_W-1:0] pos_r;
  logic             load, job_done;
  logic [7:0]       fbyte;

  assign load     = !out_valid_r || pop;
  assign job_done = !q_job.is_tx || (pos_r == POS_END);
  assign q_pop    = load && !q_empty && job_done;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_comb begin
    unique case (pos_r)
      POS_START:   fbyte = FRAME_START;
      POS_VERSION: fbyte = FRAME_VERSION;
      POS_LENGTH:  fbyte = FRAME_LENGTH;
      POS_CMD:     fbyte = q_job.command;
      POS_REPLY:   fbyte = {7'h00, q_job.reply};
      POS_PARAM_H: fbyte = q_job.param[15:8];
      POS_PARAM_L: fbyte = q_job.param[7:0];
      POS_CK_H:    fbyte = q_job.cksum[15:8];
      POS_CK_L:    fbyte = q_job.cksum[7:0];
      POS_END:     fbyte = FRAME_END;
      default:     fbyte = 8'h00;
    endcase
    res.is_tx         = q_job.is_tx;
    res.tx_byte       = q_job.is_tx ? fbyte : 8'h00;
    res.last          = job_done;
    res.completed     = (q_job.held_cmd != 8'h00);
    res.reply_command = q_job.held_cmd;
    res.reply_param   = q_job.held_param;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= POS_START;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        out_r <= res;
        pos_r <= job_done ? POS_START : pos_r + POS_W'(1);
      end
    end
  end

endmodule

### hw/rtl/serial_command_frame_codec.sv
`timescale 1ns / 1ps

// Serial command framer and reply deframer. A send item (op=1) yields ten
// result beats, the frame bytes 7E FF 06 cmd reply paramH paramL ckH ckL EF,
// one per cycle while results are popped; the back end's frame byte counter
// sets the beat count. A received byte (op=0) is checked against the ten-byte
// window in the cycle it is accepted and yields one status beat, so receive
// items run at one per cycle while results are popped. Accepted items wait in
// a job queue of QUEUE_DEPTH entries in front of the byte emitter, and the
// first beat of an item passes its queue entry and the output register.
module serial_command_frame_codec #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  sfc_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output sfc_pkg::out_t out_data
);
  import sfc_pkg::*;

  logic accept;
  job_t new_job, head_job;
  logic q_empty, q_pop;

  assign accept = push && !full;

  sfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .job    (new_job)
  );

  sfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_job (new_job),
    .rd_en  (q_pop),
    .rd_job (head_job),
    .full   (full),
    .empty  (q_empty)
  );

  sfc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (head_job),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  a_rx_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.is_tx) |-> (out_data.last && out_data.tx_byte == 8'h00))
    else $error("receive status beat not single or carries a byte");

  a_completed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.completed == (out_data.reply_command != 8'h00)))
    else $error("completed disagrees with reply command");

  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_data.is_tx && !out_data.last) |=>
      (!empty && out_data.is_tx))
    else $error("frame broken off before its end byte");

  a_send_clears_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.is_tx) |-> (out_data.reply_command == 8'h00))
    else $error("send beat shows a latched reply");
`endif

endmodule
